@@ src/jtl_pkg.sv @@
`timescale 1ns / 1ps
package jtl_pkg;

	// Accumulator widths
	localparam int NUM_W = 64;
	localparam int EXP_W = 16;

	// Result queue sizing: a byte may cause up to three items
	localparam int MAX_RES = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// Token kinds
	localparam logic [3:0] K_WHITE    = 4'd0;
	localparam logic [3:0] K_LBRACE   = 4'd1;
	localparam logic [3:0] K_RBRACE   = 4'd2;
	localparam logic [3:0] K_COLON    = 4'd3;
	localparam logic [3:0] K_LBRACKET = 4'd4;
	localparam logic [3:0] K_RBRACKET = 4'd5;
	localparam logic [3:0] K_COMMA    = 4'd6;
	localparam logic [3:0] K_NULL     = 4'd7;
	localparam logic [3:0] K_NUMBER   = 4'd10;
	localparam logic [3:0] K_STRCHAR  = 4'd11;
	localparam logic [3:0] K_STREND   = 4'd12;
	localparam logic [3:0] K_END      = 4'd13;
	localparam logic [3:0] K_ERROR    = 4'd14;

	// Error codes
	localparam logic [2:0] E_NUMBER = 3'd3;
	localparam logic [2:0] E_ESCAPE = 3'd4;
	localparam logic [2:0] E_UNEXP  = 3'd5;

	// Number flag bits
	localparam int F_NEG  = 0;
	localparam int F_FRAC = 1;
	localparam int F_EXP  = 2;
	localparam int F_EPOS = 3;

	typedef enum logic [12:0] {
		M_IDLE  = 13'b0000000000001,
		M_KEY   = 13'b0000000000010,
		M_SIGN  = 13'b0000000000100,
		M_ZERO  = 13'b0000000001000,
		M_INT   = 13'b0000000010000,
		M_DOT   = 13'b0000000100000,
		M_FRAC  = 13'b0000001000000,
		M_E     = 13'b0000010000000,
		M_ESIGN = 13'b0000100000000,
		M_EXP   = 13'b0001000000000,
		M_STR   = 13'b0010000000000,
		M_ESC   = 13'b0100000000000,
		M_ERR   = 13'b1000000000000
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  char_value;
		logic [2:0]  error_code;
		logic        is_negative;
		logic [63:0] int_value;
		logic        has_fraction;
		logic [63:0] frac_value;
		logic        has_exponent;
		logic        exp_positive;
		logic [15:0] exp_value;
		logic        last_of_run;
	} result_t;

	// Items caused by one byte, handed from the lexer to the queue
	typedef struct packed {
		logic [1:0]           count;
		result_t [MAX_RES-1:0] res;
	} burst_t;

	function automatic result_t simple_res(logic [3:0] kind, logic [7:0] ch, logic [2:0] err);
		result_t r;
		r            = '0;
		r.kind       = kind;
		r.char_value = ch;
		r.error_code = err;
		return r;
	endfunction

	function automatic result_t number_res(logic [3:0] fl, logic [NUM_W-1:0] ia,
			logic [NUM_W-1:0] fa, logic [EXP_W-1:0] ea);
		result_t r;
		r              = '0;
		r.kind         = K_NUMBER;
		r.is_negative  = fl[F_NEG];
		r.int_value    = 64'(ia);
		r.has_fraction = fl[F_FRAC];
		r.frac_value   = 64'(fa);
		r.has_exponent = fl[F_EXP];
		r.exp_positive = fl[F_EXP] & fl[F_EPOS];
		r.exp_value    = 16'(ea);
		return r;
	endfunction

	// acc*10 + d, saturating; overflow shows in the top four bits
	function automatic logic [NUM_W-1:0] sat_num(logic [NUM_W-1:0] acc, logic [3:0] d);
		logic [NUM_W+3:0] t;
		t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUM_W+4)'(d);
		return (t[NUM_W+3:NUM_W] != 4'd0) ? {NUM_W{1'b1}} : t[NUM_W-1:0];
	endfunction

	function automatic logic [EXP_W-1:0] sat_exp(logic [EXP_W-1:0] acc, logic [3:0] d);
		logic [EXP_W+3:0] t;
		t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (EXP_W+4)'(d);
		return (t[EXP_W+3:EXP_W] != 4'd0) ? {EXP_W{1'b1}} : t[EXP_W-1:0];
	endfunction

	// Letters of null / true / false
	function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] p);
		logic [39:0] s;
		case (w)
			2'd0:    s = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
			2'd1:    s = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
			default: s = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
		endcase
		return s[8*(4-int'(p)) +: 8];
	endfunction

	function automatic logic [2:0] kw_len(logic [1:0] w);
		return (w == 2'd2) ? 3'd5 : 3'd4;
	endfunction

	// Escape letter to character; bit 8 marks a valid escape
	function automatic logic [8:0] esc_map(logic [7:0] c);
		logic [8:0] v;
		case (c)
			8'h22:   v = {1'b1, 8'h22};
			8'h5C:   v = {1'b1, 8'h5C};
			8'h2F:   v = {1'b1, 8'h2F};
			8'h62:   v = {1'b1, 8'h08};
			8'h66:   v = {1'b1, 8'h0C};
			8'h6E:   v = {1'b1, 8'h0A};
			8'h72:   v = {1'b1, 8'h0D};
			8'h74:   v = {1'b1, 8'h09};
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/jtl_core.sv @@
`timescale 1ns / 1ps
module jtl_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  jtl_pkg::text_t  item,
	output jtl_pkg::burst_t burst
);

	jtl_pkg::mode_t                mode_q, m;
	logic [1:0]                    kw_w_q, kw_w;
	logic [2:0]                    kw_p_q, kw_p;
	logic [jtl_pkg::NUM_W-1:0]     ia_q, ia, fa_q, fa;
	logic [jtl_pkg::EXP_W-1:0]     ea_q, ea;
	logic [3:0]                    fl_q, fl;
	logic [1:0]                    n;
	jtl_pkg::result_t [jtl_pkg::MAX_RES-1:0] res;
	logic                          do_idle;
	logic [7:0]                    c;
	logic [3:0]                    d;
	logic                          dig;
	logic [8:0]                    esc;

	assign c   = item.text_byte;
	assign d   = c[3:0];
	assign dig = (c >= 8'h30) && (c <= 8'h39);
	assign esc = jtl_pkg::esc_map(c);

	// Next state and items for the byte in the input register
	always_comb begin
		m       = mode_q;
		kw_w    = kw_w_q;
		kw_p    = kw_p_q;
		ia      = ia_q;
		fa      = fa_q;
		ea      = ea_q;
		fl      = fl_q;
		n       = 2'd0;
		res     = '0;
		do_idle = 1'b0;

		unique case (m)
			jtl_pkg::M_IDLE: do_idle = 1'b1;
			jtl_pkg::M_KEY: begin
				if (kw_p < jtl_pkg::kw_len(kw_w) && c == jtl_pkg::kw_char(kw_w, kw_p)) begin
					kw_p = kw_p + 3'd1;
					if (kw_p == jtl_pkg::kw_len(kw_w)) begin
						res[n] = jtl_pkg::simple_res(jtl_pkg::K_NULL + {2'b0, kw_w}, 8'd0, 3'd0);
						n      = n + 2'd1;
						m      = jtl_pkg::M_IDLE;
						kw_p   = 3'd0;
					end
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, {1'b0, kw_w});
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_SIGN: begin
				if (c == 8'h30) m = jtl_pkg::M_ZERO;
				else if (dig) begin
					ia = jtl_pkg::NUM_W'(d);
					m  = jtl_pkg::M_INT;
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_ZERO, jtl_pkg::M_INT: begin
				if (dig) begin
					if (m == jtl_pkg::M_ZERO) begin
						res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
						n      = n + 2'd1;
						m      = jtl_pkg::M_ERR;
					end else ia = jtl_pkg::sat_num(ia, d);
				end else if (c == 8'h2E) m = jtl_pkg::M_DOT;
				else if (c == 8'h65 || c == 8'h45) m = jtl_pkg::M_E;
				else begin
					res[n]  = jtl_pkg::number_res(fl, ia, fa, ea);
					n       = n + 2'd1;
					m       = jtl_pkg::M_IDLE;
					do_idle = 1'b1;
				end
			end
			jtl_pkg::M_DOT: begin
				if (dig) begin
					fl[jtl_pkg::F_FRAC] = 1'b1;
					fa = jtl_pkg::NUM_W'(d);
					m  = jtl_pkg::M_FRAC;
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_FRAC: begin
				if (dig) fa = jtl_pkg::sat_num(fa, d);
				else if (c == 8'h65 || c == 8'h45) m = jtl_pkg::M_E;
				else begin
					res[n]  = jtl_pkg::number_res(fl, ia, fa, ea);
					n       = n + 2'd1;
					m       = jtl_pkg::M_IDLE;
					do_idle = 1'b1;
				end
			end
			jtl_pkg::M_E: begin
				if (c == 8'h2B || c == 8'h2D) begin
					fl[jtl_pkg::F_EXP] = 1'b1;
					if (c == 8'h2B) fl[jtl_pkg::F_EPOS] = 1'b1;
					m = jtl_pkg::M_ESIGN;
				end else if (dig) begin
					fl[jtl_pkg::F_EXP]  = 1'b1;
					fl[jtl_pkg::F_EPOS] = 1'b1;
					ea = jtl_pkg::EXP_W'(d);
					m  = jtl_pkg::M_EXP;
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_ESIGN: begin
				if (dig) begin
					ea = jtl_pkg::EXP_W'(d);
					m  = jtl_pkg::M_EXP;
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_EXP: begin
				if (dig) ea = jtl_pkg::sat_exp(ea, d);
				else begin
					res[n]  = jtl_pkg::number_res(fl, ia, fa, ea);
					n       = n + 2'd1;
					m       = jtl_pkg::M_IDLE;
					do_idle = 1'b1;
				end
			end
			jtl_pkg::M_STR: begin
				if (c == 8'h22) begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_STREND, 8'd0, 3'd0);
					n      = n + 2'd1;
					m      = jtl_pkg::M_IDLE;
				end else if (c == 8'h5C) m = jtl_pkg::M_ESC;
				else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_STRCHAR, c, 3'd0);
					n      = n + 2'd1;
				end
			end
			jtl_pkg::M_ESC: begin
				if (esc[8]) begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_STRCHAR, esc[7:0], 3'd0);
					n      = n + 2'd1;
					m      = jtl_pkg::M_STR;
				end else begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_ESCAPE);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
			end
			jtl_pkg::M_ERR: ;
			default: m = jtl_pkg::M_ERR;
		endcase

		// Byte outside any token, also the byte that closed a number
		if (do_idle) begin
			case (c) inside
				8'h20, 8'h0D, 8'h0A: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_WHITE, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h7B: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_LBRACE, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h7D: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_RBRACE, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h3A: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_COLON, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h5B: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_LBRACKET, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h5D: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_RBRACKET, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h2C: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_COMMA, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				8'h6E, 8'h74, 8'h66: begin
					kw_w = (c == 8'h6E) ? 2'd0 : (c == 8'h74) ? 2'd1 : 2'd2;
					kw_p = 3'd1;
					m    = jtl_pkg::M_KEY;
				end
				8'h22: m = jtl_pkg::M_STR;
				8'h2D: begin
					ia = '0;
					fa = '0;
					ea = '0;
					fl = 4'd0;
					fl[jtl_pkg::F_NEG] = 1'b1;
					m  = jtl_pkg::M_SIGN;
				end
				default: begin
					if (dig) begin
						ia = jtl_pkg::NUM_W'(d);
						fa = '0;
						ea = '0;
						fl = 4'd0;
						m  = (c == 8'h30) ? jtl_pkg::M_ZERO : jtl_pkg::M_INT;
					end else begin
						res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_UNEXP);
						n      = n + 2'd1;
						m      = jtl_pkg::M_ERR;
					end
				end
			endcase
		end

		// Close whatever is open at the last byte, then back to reset values
		if (item.end_of_text) begin
			unique case (m)
				jtl_pkg::M_ZERO, jtl_pkg::M_INT, jtl_pkg::M_FRAC, jtl_pkg::M_EXP: begin
					res[n] = jtl_pkg::number_res(fl, ia, fa, ea);
					n      = n + 2'd1;
				end
				jtl_pkg::M_SIGN, jtl_pkg::M_DOT, jtl_pkg::M_E, jtl_pkg::M_ESIGN: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_NUMBER);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
				jtl_pkg::M_KEY: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, {1'b0, kw_w});
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
				jtl_pkg::M_STR: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_STREND, 8'd0, 3'd0);
					n      = n + 2'd1;
				end
				jtl_pkg::M_ESC: begin
					res[n] = jtl_pkg::simple_res(jtl_pkg::K_ERROR, 8'd0, jtl_pkg::E_ESCAPE);
					n      = n + 2'd1;
					m      = jtl_pkg::M_ERR;
				end
				default: ;
			endcase
			if (m != jtl_pkg::M_ERR) begin
				res[n] = jtl_pkg::simple_res(jtl_pkg::K_END, 8'd0, 3'd0);
				n      = n + 2'd1;
			end
			m    = jtl_pkg::M_IDLE;
			kw_w = 2'd0;
			kw_p = 3'd0;
			ia   = '0;
			fa   = '0;
			ea   = '0;
			fl   = 4'd0;
		end

		if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
	end

	assign burst.count = n;
	assign burst.res   = res;

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jtl_pkg::M_IDLE;
			kw_w_q <= 2'd0;
			kw_p_q <= 3'd0;
			ia_q   <= '0;
			fa_q   <= '0;
			ea_q   <= '0;
			fl_q   <= 4'd0;
		end else if (fire) begin
			mode_q <= m;
			kw_w_q <= kw_w;
			kw_p_q <= kw_p;
			ia_q   <= ia;
			fa_q   <= fa;
			ea_q   <= ea;
			fl_q   <= fl;
		end
	end

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_text |=> mode_q == jtl_pkg::M_IDLE && fl_q == 4'd0)
		else $error("lexer not back to idle after last byte");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_q == jtl_pkg::M_ERR && !item.end_of_text |-> burst.count == 2'd0)
		else $error("items produced in error mode");

endmodule

@@ src/jtl_outq.sv @@
`timescale 1ns / 1ps
module jtl_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jtl_pkg::burst_t  burst,
	output logic             room,
	output logic             valid,
	input  logic             stall,
	output jtl_pkg::result_t item
);

	jtl_pkg::result_t      mem_q [jtl_pkg::Q_DEPTH];
	logic [jtl_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [jtl_pkg::Q_AW:0]   cnt_q;
	logic                     pop;
	logic [jtl_pkg::Q_AW:0]   add;

	assign room  = cnt_q <= (jtl_pkg::Q_AW+1)'(jtl_pkg::Q_DEPTH - jtl_pkg::MAX_RES);
	assign valid = cnt_q != '0;
	assign item  = mem_q[rd_ptr_q];
	assign pop   = valid && !stall;
	assign add   = push ? (jtl_pkg::Q_AW+1)'(burst.count) : '0;

	// Item storage, up to three writes per cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < jtl_pkg::MAX_RES; i++) begin
			if (push && i < int'(burst.count))
				mem_q[wr_ptr_q + jtl_pkg::Q_AW'(i)] <= burst.res[i];
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + add[jtl_pkg::Q_AW-1:0];
			rd_ptr_q <= rd_ptr_q + jtl_pkg::Q_AW'(pop);
			cnt_q    <= cnt_q + add - (jtl_pkg::Q_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (jtl_pkg::Q_AW+1)'(jtl_pkg::Q_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push without room");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("fill level did not drop on pop");

endmodule

@@ src/json_token_lexer.sv @@
`timescale 1ns / 1ps
// An accepted byte is held in the input register; its tokens then enter the queue.
// Throughput: one byte per cycle while each byte gives at most one token and
// tok_stall is low; a byte giving two or three tokens holds the input until the
// result queue (four entries, one token out per cycle) has room for three again.
// Reset (arst_n low, asynchronous): lexer idle, accumulators cleared, queue empty.
module json_token_lexer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	output logic             text_stall,
	input  jtl_pkg::text_t   text_item,
	output logic             tok_valid,
	input  logic             tok_stall,
	output jtl_pkg::result_t tok_item
);

	jtl_pkg::text_t  item_s1;
	logic            vld_s1;
	logic            room;
	logic            fire;
	logic            accept;
	jtl_pkg::burst_t burst;

	assign fire       = vld_s1 && room;
	assign text_stall = vld_s1 && !room;
	assign accept     = text_valid && !text_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= text_item;
	end

	jtl_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.burst (burst)
	);

	jtl_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fire),
		.burst (burst),
		.room  (room),
		.valid (tok_valid),
		.stall (tok_stall),
		.item  (tok_item)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !fire |=> vld_s1 && $stable(item_s1))
		else $error("held byte lost");

endmodule
